// File: hdl/interval_bin_table_macros.svh
// Assertion macros for the interval bin table
`ifndef INTERVAL_BIN_TABLE_MACROS_SVH
`define INTERVAL_BIN_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define IBT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same cycle implication");
`define IBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle implication");
`else
`define IBT_ASSERT_SAME(label, clk, rst, ante, cons)
`define IBT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hdl/ibt_pkg.sv
`timescale 1ns / 1ps
package ibt_pkg;

   localparam int MAX_BINS_DEF   = 16;
   localparam int LIMIT_BITS_DEF = 32;
   localparam int FIELD_W        = 32;
   localparam int ID_W           = 9;
   localparam int STATUS_W       = 3;

   localparam logic [1:0] FUNC_ADD        = 2'd0;
   localparam logic [1:0] FUNC_FIND_VALUE = 2'd1;
   localparam logic [1:0] FUNC_FIND_EXACT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXISTING = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

   localparam logic signed [ID_W-1:0] OOR_ID_RESET = -9'sd1;

   typedef struct packed {
      logic [1:0]                 func;
      logic signed [FIELD_W-1:0]  lower_limit;
      logic signed [FIELD_W-1:0]  upper_limit;
      logic signed [FIELD_W-1:0]  value_in;
   } req_word_type;

   typedef struct packed {
      logic signed [ID_W-1:0]  bin_id;
      logic [STATUS_W-1:0]     status;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic read;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic scan_last;
      logic out_free;
   } ctl_stat_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SCAN,
      CTL_DRAIN,
      CTL_RESULT
   } ctl_state_type;

endpackage

// File: hdl/ibt_ctrl.sv
`timescale 1ns / 1ps
module ibt_ctrl import ibt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ctl_stat_type  stat,
   output ctl_cmd_type   cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = stat.empty ? CTL_RESULT : CTL_SCAN;
            end
         end
         CTL_SCAN: begin
            cmd.read = 1'b1;
            if (stat.scan_last) begin
               state_in = CTL_DRAIN;
            end
         end
         CTL_DRAIN: begin
            state_in = CTL_RESULT;
         end
         CTL_RESULT: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/ibt_datapath.sv
`timescale 1ns / 1ps
module ibt_datapath import ibt_pkg::*; #(
   parameter int MAX_BINS   = MAX_BINS_DEF,
   parameter int LIMIT_BITS = LIMIT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  req_word_type            req_word,
   input  logic                    csr_wr_en,
   input  logic signed [ID_W-1:0]  csr_wr_data,
   input  ctl_cmd_type             cmd,
   output ctl_stat_type            stat,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_word_type            rsp_word
);

   localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CNT_W = $clog2(MAX_BINS + 1);

   function automatic logic signed [LIMIT_BITS-1:0] to_limit(input logic signed [FIELD_W-1:0] x);
      logic signed [63:0] w;
      w = 64'(x);
      return w[LIMIT_BITS-1:0];
   endfunction

   logic signed [LIMIT_BITS-1:0] lower_mem [MAX_BINS];
   logic signed [LIMIT_BITS-1:0] upper_mem [MAX_BINS];

   logic [CNT_W-1:0]              count_ff;
   logic signed [ID_W-1:0]        oor_ff;
   logic [1:0]                    func_ff;
   logic signed [LIMIT_BITS-1:0]  lo_ff;
   logic signed [LIMIT_BITS-1:0]  hi_ff;
   logic signed [LIMIT_BITS-1:0]  val_ff;
   logic [IDX_W-1:0]              scan_ff;
   logic signed [LIMIT_BITS-1:0]  rd_lo_ff;
   logic signed [LIMIT_BITS-1:0]  rd_hi_ff;
   logic [IDX_W-1:0]              rd_idx_ff;
   logic                          rd_vld_ff;
   logic                          exact_hit_ff;
   logic [IDX_W-1:0]              exact_idx_ff;
   logic                          val_hit_ff;
   logic [IDX_W-1:0]              val_idx_ff;
   logic                          ovl_ff;
   logic                          rsp_valid_ff;
   rsp_word_type                  rsp_ff;

   logic          exact_now;
   logic          inval_now;
   logic          ovl_now;
   logic          add_new;
   rsp_word_type  rsp_in;

   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CNT_W'(MAX_BINS));
   assign stat.scan_last = (CNT_W'(scan_ff) == count_ff - CNT_W'(1));
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign exact_now = (rd_lo_ff == lo_ff) && (rd_hi_ff == hi_ff);
   assign inval_now = (val_ff >= rd_lo_ff) && (val_ff < rd_hi_ff);
   assign ovl_now   = ((lo_ff >= rd_lo_ff) && (lo_ff < rd_hi_ff))
                   || ((hi_ff > rd_lo_ff) && (hi_ff <= rd_hi_ff))
                   || ((lo_ff < rd_lo_ff) && (hi_ff > rd_hi_ff));

   always_comb begin
      add_new       = 1'b0;
      rsp_in.bin_id = oor_ff;
      rsp_in.status = ST_MISS;
      case (func_ff)
         FUNC_ADD: begin
            if (exact_hit_ff) begin
               rsp_in.bin_id = $signed(ID_W'(exact_idx_ff) + ID_W'(1));
               rsp_in.status = ST_EXISTING;
            end else if (ovl_ff) begin
               rsp_in.status = ST_OVERLAP;
            end else if (stat.full) begin
               rsp_in.status = ST_FULL;
            end else begin
               add_new       = 1'b1;
               rsp_in.bin_id = $signed(ID_W'(count_ff) + ID_W'(1));
               rsp_in.status = ST_OK;
            end
         end
         FUNC_FIND_VALUE: begin
            if (val_hit_ff) begin
               rsp_in.bin_id = $signed(ID_W'(val_idx_ff) + ID_W'(1));
               rsp_in.status = ST_OK;
            end
         end
         FUNC_FIND_EXACT: begin
            if (exact_hit_ff) begin
               rsp_in.bin_id = $signed(ID_W'(exact_idx_ff) + ID_W'(1));
               rsp_in.status = ST_OK;
            end
         end
         default: begin
            rsp_in.status = ST_MISS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         oor_ff       <= OOR_ID_RESET;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            oor_ff <= csr_wr_data;
         end
         if (cmd.finish && add_new) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_vld_ff <= cmd.read;
      end
   end

   // request capture, scan pointer, hit tracking and response register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff      <= req_word.func;
         lo_ff        <= to_limit(req_word.lower_limit);
         hi_ff        <= to_limit(req_word.upper_limit);
         val_ff       <= to_limit(req_word.value_in);
         scan_ff      <= '0;
         exact_hit_ff <= 1'b0;
         val_hit_ff   <= 1'b0;
         ovl_ff       <= 1'b0;
      end else begin
         if (cmd.read) begin
            scan_ff <= scan_ff + IDX_W'(1);
         end
         if (rd_vld_ff) begin
            if (exact_now && !exact_hit_ff) begin
               exact_hit_ff <= 1'b1;
               exact_idx_ff <= rd_idx_ff;
            end
            if (inval_now && !val_hit_ff) begin
               val_hit_ff <= 1'b1;
               val_idx_ff <= rd_idx_ff;
            end
            if (ovl_now) begin
               ovl_ff <= 1'b1;
            end
         end
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_lo_ff  <= lower_mem[scan_ff];
         rd_hi_ff  <= upper_mem[scan_ff];
         rd_idx_ff <= scan_ff;
      end
      if (cmd.finish && add_new) begin
         lower_mem[count_ff[IDX_W-1:0]] <= lo_ff;
         upper_mem[count_ff[IDX_W-1:0]] <= hi_ff;
      end
   end

endmodule

// File: hdl/interval_bin_table.sv
// One request in flight at a time: req_ready stays low from the accepting edge until the response
// is registered. Each request scans the stored entries one entry per cycle through the single
// read port of the limit memories.
// Reset: synchronous, active high; empties the table and sets out_of_range_id to -1.
// Table contents need no clearing pass.
`timescale 1ns / 1ps
`include "interval_bin_table_macros.svh"
module interval_bin_table import ibt_pkg::*; #(
   parameter int MAX_BINS   = MAX_BINS_DEF,
   parameter int LIMIT_BITS = LIMIT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_word_type            req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_word_type            rsp_word,
   input  logic                    csr_wr_en,
   input  logic signed [ID_W-1:0]  csr_wr_data
);

   ctl_cmd_type   cmd;
   ctl_stat_type  stat;

   ibt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ibt_datapath #(
      .MAX_BINS   (MAX_BINS),
      .LIMIT_BITS (LIMIT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

   `IBT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `IBT_ASSERT_NEXT(a_finish_shows, clock, reset, cmd.finish, rsp_valid)
   `IBT_ASSERT_SAME(a_finish_slot_free, clock, reset, cmd.finish, !rsp_valid || rsp_ready)
   `IBT_ASSERT_SAME(a_scan_not_empty, clock, reset, cmd.read, !stat.empty)

endmodule
